### rtl/pixel_to_hex_cube_round_defines.svh
// Assertion macros for the pixel to hex cube rounding block.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef PIXEL_TO_HEX_CUBE_ROUND_DEFINES_SVH
`define PIXEL_TO_HEX_CUBE_ROUND_DEFINES_SVH

// Check that the consequent holds whenever the antecedent holds, outside reset.
`define P2H_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds at every clock edge outside reset.
`define P2H_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

### rtl/p2h_pkg.sv
// Shared constants, lane indexes and width helpers for the hex cube rounding pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package p2h_pkg;

    // Fixed field widths
    localparam int POS_W   = 24;
    localparam int RECIP_W = 24;
    localparam int HEX_W   = 16;
    localparam int PROD_W  = 48;
    localparam int ERR_W   = 31;
    localparam int LOW_W   = 30;

    // Scaling: position times reciprocal keeps 12 fraction bits after this extra shift
    localparam int SCALE_EXTRA = 4;
    localparam int MAG_SHIFT   = 18;
    localparam int K_W         = 19;

    localparam int unsigned FRAC_BITS_DEFAULT = 8;

    // Lanes of the cube coordinate vector
    localparam int LANES  = 3;
    localparam int LANE_Q = 0;
    localparam int LANE_R = 1;
    localparam int LANE_S = 2;

    localparam logic [RECIP_W-1:0] SPACING_RECIP_RESET = 24'd262144;
    // sqrt(3) in Q.18, rounded to nearest
    localparam logic [K_W-1:0]     SQRT3_Q18           = 19'd454047;
    // Half of the divisor 3 * 2^30
    localparam logic [31:0]        ROUND_BIAS          = 32'h6000_0000;

    localparam logic signed [HEX_W-1:0] HEX_MAX = 16'sh7FFF;
    localparam logic signed [HEX_W-1:0] HEX_MIN = 16'sh8000;

    // Width of the scaled position (signed)
    function automatic int ux_width(input int unsigned frac_bits);
        return PROD_W - int'(frac_bits) - SCALE_EXTRA;
    endfunction

    // Width of sqrt(3) times scaled y (signed)
    function automatic int kuy_width(input int unsigned frac_bits);
        return ux_width(frac_bits) + K_W;
    endfunction

    // Width of the cube coordinates scaled by 3 * 2^30 (signed)
    function automatic int abc_width(input int unsigned frac_bits);
        return ux_width(frac_bits) + 20;
    endfunction

    // Width of the biased magnitude above the low 30 bits; also the signed coordinate width
    function automatic int quo_width(input int unsigned frac_bits);
        return abc_width(frac_bits) - LOW_W;
    endfunction

endpackage

`default_nettype wire

### rtl/pixel_to_hex_cube_round.sv
// Flat-top hex cell lookup: maps a Q16.8 position to cube coordinates (q, r, s) of the
// containing cell. The block is an eight-stage pipeline and takes one transfer per clock
// cycle unless a held output has filled every stage. The stage split is set by the two
// scaling multipliers, the sqrt(3) multiplier and the reciprocal multiply that divides
// by three, each given a stage of its own. Every stage carries a valid bit and loads when
// empty or when the next stage loads, so a held output only stalls the input once all
// stages are full. spacing_recip (unsigned Q8.16, reset 4.0) is written through
// cfg_we/cfg_wdata; write it only while the pipeline is empty.
// Depends on p2h_pkg, p2h_scale, p2h_cube, p2h_round, p2h_select and the defines header.
`default_nettype none
`include "pixel_to_hex_cube_round_defines.svh"

module pixel_to_hex_cube_round
    import p2h_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic        [RECIP_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [POS_W-1:0]   s_pos_x,
    input  logic signed [POS_W-1:0]   s_pos_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [HEX_W-1:0]   m_hex_q,
    output logic signed [HEX_W-1:0]   m_hex_r,
    output logic signed [HEX_W-1:0]   m_hex_s,
    output logic                      m_saturated
);

    localparam int UXW  = ux_width(FRAC_BITS);
    localparam int KUYW = kuy_width(FRAC_BITS);
    localparam int AW   = abc_width(FRAC_BITS);
    localparam int WW   = quo_width(FRAC_BITS);

    logic [RECIP_W-1:0] spacing_recip_reg;

    logic                        sc_valid, sc_ready;
    logic signed [UXW-1:0]       ux;
    logic signed [KUYW-1:0]      kuy;
    logic                        cb_valid, cb_ready;
    logic [LANES-1:0][AW-1:0]    abc;
    logic                        rd_valid, rd_ready;
    logic [LANES-1:0][WW-1:0]    coord;
    logic [LANES-1:0][ERR_W-1:0] err;

    logic [HEX_W-1:0]            cube_sum;
    logic                        sat_bound_ok;

    // Hold the spacing reciprocal
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_recip_reg <= SPACING_RECIP_RESET;
        end else if (cfg_we) begin
            spacing_recip_reg <= cfg_wdata;
        end
    end

    p2h_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .recip     (spacing_recip_reg),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .ux        (ux),
        .kuy       (kuy)
    );

    p2h_cube #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cube (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .ux        (ux),
        .kuy       (kuy),
        .out_valid (cb_valid),
        .out_ready (cb_ready),
        .abc       (abc)
    );

    p2h_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cb_valid),
        .in_ready  (cb_ready),
        .abc       (abc),
        .out_valid (rd_valid),
        .out_ready (rd_ready),
        .coord     (coord),
        .err       (err)
    );

    p2h_select #(
        .FRAC_BITS (FRAC_BITS)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid),
        .in_ready  (rd_ready),
        .coord     (coord),
        .err       (err),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .hex_q     (m_hex_q),
        .hex_r     (m_hex_r),
        .hex_s     (m_hex_s),
        .saturated (m_saturated)
    );

    // Sum of the output coordinates, and a clipped result sitting at some bound
    assign cube_sum     = m_hex_q + m_hex_r + m_hex_s;
    assign sat_bound_ok = !(m_valid && m_saturated)
                       || m_hex_q == HEX_MAX || m_hex_q == HEX_MIN
                       || m_hex_r == HEX_MAX || m_hex_r == HEX_MIN
                       || m_hex_s == HEX_MAX || m_hex_s == HEX_MIN;

    // Input back-pressure only when every stage is full and the output is held
    `P2H_ASSERT_IMP(a_stall_from_output, !s_ready, m_valid && !m_ready, "unexpected input stall")

    // Unclipped cube coordinates sum to zero
    `P2H_ASSERT_IMP(a_cube_sum_zero, m_valid && !m_saturated, cube_sum == '0, "nonzero cube sum")

    // A clipped result has some coordinate at a bound
    `P2H_ASSERT_ALWAYS(a_sat_at_bound, sat_bound_ok, "saturated flag without clipped coordinate")

endmodule

`default_nettype wire

### rtl/p2h_scale.sv
// Stages 1-2: scale the position by the spacing reciprocal, then form sqrt(3) * y.
// Depends on p2h_pkg.
`default_nettype none

module p2h_scale
    import p2h_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int UXW  = ux_width(FRAC_BITS),
    localparam int KUYW = kuy_width(FRAC_BITS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic        [RECIP_W-1:0] recip,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [UXW-1:0]     ux,
    output logic signed [KUYW-1:0]    kuy
);

    localparam int SH = int'(FRAC_BITS) + SCALE_EXTRA;
    localparam logic signed [K_W:0] K_S = signed'({1'b0, SQRT3_Q18});

    logic                     v1_reg, v2_reg;
    logic                     rdy1, rdy2;
    logic signed [RECIP_W:0]  rc_s;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_x_reg, prod_y_reg;
    logic signed [UXW-1:0]    ux_next, uy, ux_reg;
    logic signed [KUYW-1:0]   kuy_next, kuy_reg;

    // Ready chain: a stage loads when empty or when its successor loads
    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: position times reciprocal
    assign rc_s        = signed'({1'b0, recip});
    assign prod_x_next = PROD_W'(pos_x * rc_s);
    assign prod_y_next = PROD_W'(pos_y * rc_s);

    // Stage 2: floor shift, then sqrt(3) * uy
    assign ux_next  = prod_x_reg[PROD_W-1:SH];
    assign uy       = prod_y_reg[PROD_W-1:SH];
    assign kuy_next = KUYW'(uy * K_S);

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (rdy2 && v1_reg) begin
            ux_reg  <= ux_next;
            kuy_reg <= kuy_next;
        end
    end

    assign out_valid = v2_reg;
    assign ux        = ux_reg;
    assign kuy       = kuy_reg;

endmodule

`default_nettype wire

### rtl/p2h_cube.sv
// Stage 3: inverse hex matrix, giving q, r, s scaled by 3 * 2^30.
// Depends on p2h_pkg.
`default_nettype none

module p2h_cube
    import p2h_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int UXW  = ux_width(FRAC_BITS),
    localparam int KUYW = kuy_width(FRAC_BITS),
    localparam int AW   = abc_width(FRAC_BITS)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [UXW-1:0]       ux,
    input  logic signed [KUYW-1:0]      kuy,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LANES-1:0][AW-1:0]    abc
);

    logic                     v3_reg;
    logic                     rdy3;
    logic signed [AW-1:0]     ux_ext, kuy_ext, ux18;
    logic [LANES-1:0][AW-1:0] abc_next, abc_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign in_ready = rdy3;

    // q = 2 * ux * 2^18, r = -ux * 2^18 + K * uy, s = -q - r
    assign ux_ext  = AW'(ux);
    assign kuy_ext = AW'(kuy);
    assign ux18    = ux_ext <<< MAG_SHIFT;

    always_comb begin
        abc_next         = '0;
        abc_next[LANE_Q] = ux_ext <<< (MAG_SHIFT + 1);
        abc_next[LANE_R] = kuy_ext - ux18;
        abc_next[LANE_S] = -ux18 - kuy_ext;
    end

    // Advance valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= in_valid;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (rdy3 && in_valid) begin
            abc_reg <= abc_next;
        end
    end

    assign out_valid = v3_reg;
    assign abc       = abc_reg;

endmodule

`default_nettype wire

### rtl/p2h_round.sv
// Stages 4-6: round each coordinate half away from zero through a divide by 3 * 2^30,
// and form its rounding error. Three independent lanes. Depends on p2h_pkg.
`default_nettype none

module p2h_round
    import p2h_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int AW = abc_width(FRAC_BITS),
    localparam int WW = quo_width(FRAC_BITS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LANES-1:0][AW-1:0]     abc,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LANES-1:0][WW-1:0]     coord,
    output logic [LANES-1:0][ERR_W-1:0]  err
);

    // floor(w / 3) = (w * DIV3_MUL) >> KD, exact for w < 2^(KD-1)
    localparam int KD = WW + 1;
    localparam int DW = 2 * WW;
    localparam int NW = WW - 1;
    localparam logic [WW-1:0] DIV3_MUL = WW'(((64'd1 << KD) + 64'd2) / 64'd3);

    logic v4_reg, v5_reg, v6_reg;
    logic rdy4, rdy5, rdy6;

    logic [LANES-1:0][WW-1:0]    w_next, w_reg;
    logic [LANES-1:0][LOW_W-1:0] low_next, low4_reg, low5_reg;
    logic [LANES-1:0]            neg_next, neg4_reg, neg5_reg;
    logic [LANES-1:0][DW-1:0]    dprod_next, dprod_reg;
    logic [LANES-1:0][1:0]       w2_reg;
    logic [LANES-1:0][WW-1:0]    coord_next, coord_reg;
    logic [LANES-1:0][ERR_W-1:0] err_next, err_reg;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // Stage 4: magnitude plus half divisor in one add, split at bit 30
    always_comb begin
        logic [AW-1:0] t;
        w_next   = '0;
        low_next = '0;
        neg_next = '0;
        for (int i = 0; i < LANES; i++) begin
            neg_next[i] = abc[i][AW-1];
            t = (neg_next[i] ? ~abc[i] : abc[i]) + AW'(ROUND_BIAS) + AW'(neg_next[i]);
            w_next[i]   = t[AW-1:LOW_W];
            low_next[i] = t[LOW_W-1:0];
        end
    end

    // Stage 5: reciprocal multiply for the divide by 3
    always_comb begin
        dprod_next = '0;
        for (int i = 0; i < LANES; i++) begin
            dprod_next[i] = DW'(w_reg[i] * DIV3_MUL);
        end
    end

    // Stage 6: quotient, remainder, signed coordinate and error
    always_comb begin
        logic [NW-1:0]     n;
        logic [1:0]        rem3;
        logic [31:0]       f;
        logic signed [32:0] d;
        coord_next = '0;
        err_next   = '0;
        for (int i = 0; i < LANES; i++) begin
            n    = dprod_reg[i][DW-1:KD];
            rem3 = 2'(w2_reg[i] - (n[1:0] + {n[0], 1'b0}));
            f    = {rem3, low5_reg[i]};
            d    = signed'({1'b0, ROUND_BIAS}) - signed'({1'b0, f});
            err_next[i]   = d[32] ? ERR_W'(-d) : ERR_W'(d);
            coord_next[i] = neg5_reg[i] ? -WW'(n) : WW'(n);
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
            if (rdy6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            w_reg    <= w_next;
            low4_reg <= low_next;
            neg4_reg <= neg_next;
        end
        if (rdy5 && v4_reg) begin
            dprod_reg <= dprod_next;
            low5_reg  <= low4_reg;
            neg5_reg  <= neg4_reg;
            for (int i = 0; i < LANES; i++) begin
                w2_reg[i] <= w_reg[i][1:0];
            end
        end
        if (rdy6 && v5_reg) begin
            coord_reg <= coord_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid = v6_reg;
    assign coord     = coord_reg;
    assign err       = err_reg;

endmodule

`default_nettype wire

### rtl/p2h_select.sv
// Stages 7-8: rebuild the coordinate with the largest rounding error, then saturate
// to 16 bits into the output register. Depends on p2h_pkg.
`default_nettype none

module p2h_select
    import p2h_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT,
    localparam int WW = quo_width(FRAC_BITS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [LANES-1:0][WW-1:0]     coord,
    input  logic [LANES-1:0][ERR_W-1:0]  err,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [HEX_W-1:0]      hex_q,
    output logic signed [HEX_W-1:0]      hex_r,
    output logic signed [HEX_W-1:0]      hex_s,
    output logic                         saturated
);

    localparam int RW = WW + 1;
    localparam logic signed [RW-1:0] SAT_HI = RW'(HEX_MAX);
    localparam logic signed [RW-1:0] SAT_LO = RW'(HEX_MIN);

    logic v7_reg, v8_reg;
    logic rdy7, rdy8;

    logic signed [RW-1:0]         qx, rx, sx;
    logic                         pick_q, pick_r;
    logic [LANES-1:0][RW-1:0]     fin_next, fin_reg;
    logic [LANES-1:0][HEX_W-1:0]  hex_next, hex_reg;
    logic                         sat_next, sat_reg;

    assign rdy8     = !v8_reg || out_ready;
    assign rdy7     = !v7_reg || rdy8;
    assign in_ready = rdy7;

    // Stage 7: q wins only when strictly largest, then r only when strictly above s, else s
    assign qx     = RW'(signed'(coord[LANE_Q]));
    assign rx     = RW'(signed'(coord[LANE_R]));
    assign sx     = RW'(signed'(coord[LANE_S]));
    assign pick_q = (err[LANE_Q] > err[LANE_R]) && (err[LANE_Q] > err[LANE_S]);
    assign pick_r = !pick_q && (err[LANE_R] > err[LANE_S]);

    always_comb begin
        fin_next         = '0;
        fin_next[LANE_Q] = pick_q ? -rx - sx : qx;
        fin_next[LANE_R] = pick_r ? -qx - sx : rx;
        fin_next[LANE_S] = (!pick_q && !pick_r) ? -qx - rx : sx;
    end

    // Stage 8: clip to 16 bits and flag it
    always_comb begin
        logic signed [RW-1:0] v;
        hex_next = '0;
        sat_next = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            v = signed'(fin_reg[i]);
            if (v > SAT_HI) begin
                hex_next[i] = HEX_MAX;
                sat_next    = 1'b1;
            end else if (v < SAT_LO) begin
                hex_next[i] = HEX_MIN;
                sat_next    = 1'b1;
            end else begin
                hex_next[i] = HEX_W'(v);
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else begin
            if (rdy7) begin
                v7_reg <= in_valid;
            end
            if (rdy8) begin
                v8_reg <= v7_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (rdy7 && in_valid) begin
            fin_reg <= fin_next;
        end
        if (rdy8 && v7_reg) begin
            hex_reg <= hex_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v8_reg;
    assign hex_q     = signed'(hex_reg[LANE_Q]);
    assign hex_r     = signed'(hex_reg[LANE_R]);
    assign hex_s     = signed'(hex_reg[LANE_S]);
    assign saturated = sat_reg;

endmodule

`default_nettype wire
